// File: sv/adaptive_strategy_table_sampler_top_assert.svh
// Assertion macros shared by the sampler RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ADAPTIVE_STRATEGY_TABLE_SAMPLER_TOP_ASSERT_SVH
`define ADAPTIVE_STRATEGY_TABLE_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ASTS_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASTS_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/asts_pkg.sv
// ----------------------------------------------------------------------------
// asts_pkg
// Shared widths, command codes, reset table and types of the sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asts_pkg;

    localparam int MAX_VERTS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 32;
    localparam int RAND_W   = 16;
    localparam int PROB_W   = 17;
    localparam int WEIGHT_W = 32;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 48;
    localparam int DVD_W    = 64;

    localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [WEIGHT_W-1:0] LOW_FLOOR  = 32'd6554;
    localparam logic [WEIGHT_W-1:0] EDGE_FLOOR = 32'd655360;
    localparam logic [COUNT_W-1:0]  COUNT_INIT = 32'd1000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;

    // 100*exp(-k*k/20) in Q16.16.
    localparam logic [WEIGHT_W-1:0] DECAY [12] = '{
        32'd6553600, 32'd6233977, 32'd5365634, 32'd4178760,
        32'd2944722, 32'd1877638, 32'd1083303, 32'd565534,
        32'd267139,  32'd114179,  32'd44158,   32'd15452
    };

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [WEIGHT_W-1:0] init_weight(int i, int j, int max_v);
        logic [WEIGHT_W-1:0] w;
        int k;
        k = i + j;
        if (k < 12)
        begin
            w = DECAY[k[3:0]];
        end
        else
        begin
            w = LOW_FLOOR;
        end
        if ((j <= 1 || i == 1) && w < EDGE_FLOOR)
        begin
            w = EDGE_FLOOR;
        end
        if (k > max_v || i == 0 || (i == 1 && j <= 1))
        begin
            w = '0;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/asts_if.sv
// ----------------------------------------------------------------------------
// asts_if
// Request and response channels of the sampler, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface asts_req_if;
    logic                              valid;
    logic                              ready;
    logic [asts_pkg::CMD_W-1:0]        command;
    logic [asts_pkg::IDX_W-1:0]        eye_count;
    logic [asts_pkg::IDX_W-1:0]        light_count;
    logic signed [asts_pkg::VAL_W-1:0] contribution;
    logic [asts_pkg::RAND_W-1:0]       rand_row;
    logic [asts_pkg::RAND_W-1:0]       rand_col;

    modport source (output valid, command, eye_count, light_count, contribution,
                    rand_row, rand_col, input ready);
    modport sink (input valid, command, eye_count, light_count, contribution,
                  rand_row, rand_col, output ready);
endinterface

interface asts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [asts_pkg::IDX_W-1:0]  row_out;
    logic [asts_pkg::IDX_W-1:0]  col_out;
    logic [asts_pkg::PROB_W-1:0] probability;
    logic                        status;

    modport source (output valid, row_out, col_out, probability, status, input ready);
    modport sink (input valid, row_out, col_out, probability, status, output ready);
endinterface

`default_nettype wire

// File: sv/asts_cell_mem.sv
// ----------------------------------------------------------------------------
// asts_cell_mem
// Cell store: weight and sample count per cell, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asts_cell_mem #(
    parameter int DEPTH  = 289,
    parameter int DATA_W = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]             rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/asts_div.sv
// ----------------------------------------------------------------------------
// asts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asts_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [asts_pkg::DVD_W-1:0]     dividend,
    input  wire logic [asts_pkg::TOTAL_W-1:0]   divisor,
    output logic [asts_pkg::DVD_W-1:0]          quotient,
    output asts_pkg::div_stat_t                 stat
);

    localparam int DW = asts_pkg::DVD_W;
    localparam int SW = asts_pkg::TOTAL_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    dvd_reg;
    logic [SW-1:0]    dvs_reg;
    logic [SW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SW:0] rem_sh;
    logic        ge;
    logic [SW:0] rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: sv/adaptive_strategy_table_sampler_top.sv
// ----------------------------------------------------------------------------
// adaptive_strategy_table_sampler_top
// Running-mean strategy table with accumulate, sample and query requests.
// ----------------------------------------------------------------------------
// Channel  Role    Payload
// req      sink    command, eye_count, light_count, contribution, rand_row/col
// rsp      source  row_out, col_out, probability, status
//
// One request at a time. A query uses at most one pass of the bit-serial
// divider and an accumulate at most two; a sample walks the rows, then reads
// and checks one column at a time, then divides at most once.
// After reset a sweep over all (MAX_VERTS+1)^2 cells loads the cell store.
// A waiting response does not block the next request from being accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_strategy_table_sampler_top_assert.svh"

module adaptive_strategy_table_sampler_top #(
    parameter int MAX_VERTS = asts_pkg::MAX_VERTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    asts_req_if.sink  req,
    asts_rsp_if.source rsp
);

    localparam int SIDE  = MAX_VERTS + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int IW    = $clog2(SIDE);
    localparam int AW    = $clog2(CELLS);
    localparam int WW    = asts_pkg::WEIGHT_W;
    localparam int NW    = asts_pkg::COUNT_W;
    localparam int TW    = asts_pkg::TOTAL_W;
    localparam int DW    = asts_pkg::DVD_W;
    localparam int XW    = asts_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_USE, S_MUL, S_DIVQ, S_SHARE, S_DIVS,
        S_ROW, S_CRD, S_CCHK, S_DONE
    } state_t;

    state_t state_reg;

    logic [IW-1:0]  ini_row_reg;
    logic [IW-1:0]  ini_col_reg;
    logic [AW-1:0]  ini_addr_reg;
    logic [TW-1:0]  row_total_reg [SIDE];
    logic [TW-1:0]  grand_reg;

    logic [asts_pkg::CMD_W-1:0] cmd_reg;
    logic [XW-1:0]  r_reg;
    logic [XW-1:0]  c_reg;
    logic [IW-1:0]  r_idx_reg;
    logic [AW-1:0]  idx_reg;
    logic [31:0]    x_reg;
    logic [15:0]    rc_reg;
    logic           status_reg;
    logic [WW-1:0]  old_reg;
    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  mul_reg;
    logic [WW-1:0]  wsel_reg;
    logic [DW-1:0]  prod_reg;
    logic [TW-1:0]  cum_reg;
    logic [IW-1:0]  row_reg;
    logic [IW-1:0]  col_reg;
    logic [IW-1:0]  lim_reg;
    logic [asts_pkg::PROB_W-1:0] prob_reg;

    logic                        rsp_valid_reg;
    logic [XW-1:0]               rsp_row_reg;
    logic [XW-1:0]               rsp_col_reg;
    logic [asts_pkg::PROB_W-1:0] rsp_prob_reg;
    logic                        rsp_status_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WW+NW-1:0]     mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WW+NW-1:0]     mem_rdata;

    logic                 div_start;
    logic [DW-1:0]        div_dvd;
    logic [TW-1:0]        div_dvs;
    logic [DW-1:0]        div_q;
    asts_pkg::div_stat_t  div_st;

    logic [WW-1:0] init_w;
    logic [WW-1:0] rd_w;
    logic [NW-1:0] rd_n;
    logic [WW-1:0] nw;
    logic [NW-1:0] n_sat;
    logic [TW-1:0] rt_cur;
    logic [TW-1:0] row_cum;
    logic          row_go;
    logic [TW-1:0] col_cum;
    logic          col_go;
    logic          req_fire;
    logic          out_free;
    logic          in_range;

    assign req_fire = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        init_w  = asts_pkg::init_weight(int'(ini_row_reg), int'(ini_col_reg), MAX_VERTS);
        rd_w    = mem_rdata[WW-1:0];
        rd_n    = mem_rdata[WW+NW-1:WW];
        nw      = div_q[WW-1:0];
        n_sat   = (n_reg == asts_pkg::COUNT_MAX) ? n_reg : n_reg + 1'b1;
        rt_cur  = row_total_reg[row_reg];
        row_cum = cum_reg + rt_cur;
        // Advance past rows that are empty or still below the target mass.
        row_go  = (row_reg < IW'(MAX_VERTS)) &&
                  (({row_cum, 16'b0} < prod_reg) || (rt_cur == '0));
        col_cum = cum_reg + TW'(rd_w);
        col_go  = (col_reg < lim_reg) &&
                  (({col_cum, 16'b0} < prod_reg) || (rd_w == '0));
        in_range = (int'(req.eye_count) <= MAX_VERTS) &&
                   (int'(req.light_count) <= MAX_VERTS);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ini_addr_reg;
        mem_wdata = {asts_pkg::COUNT_INIT, init_w};
        mem_raddr = idx_reg;
        div_start = 1'b0;
        div_dvd   = mul_reg + DW'(x_reg);
        div_dvs   = TW'({1'b0, n_reg} + 33'd1);
        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
            end
            S_DIVQ:
            begin
                mem_we    = div_st.done;
                mem_waddr = idx_reg;
                mem_wdata = {n_sat, nw};
            end
            S_CRD:
            begin
                mem_raddr = AW'(int'(row_reg) * SIDE + int'(col_reg));
            end
            S_MUL:
            begin
                div_start = 1'b1;
            end
            S_SHARE:
            begin
                div_start = (grand_reg != '0);
                div_dvd   = DW'({wsel_reg, 16'b0});
                div_dvs   = grand_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ini_row_reg   <= '0;
            ini_col_reg   <= '0;
            ini_addr_reg  <= '0;
            for (int i = 0; i < SIDE; i++)
            begin
                row_total_reg[i] <= '0;
            end
            grand_reg     <= '0;
            cmd_reg       <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            r_idx_reg     <= '0;
            idx_reg       <= '0;
            x_reg         <= '0;
            rc_reg        <= '0;
            status_reg    <= 1'b0;
            old_reg       <= '0;
            n_reg         <= '0;
            mul_reg       <= '0;
            wsel_reg      <= '0;
            prod_reg      <= '0;
            cum_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            lim_reg       <= '0;
            prob_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_row_reg   <= '0;
            rsp_col_reg   <= '0;
            rsp_prob_reg  <= '0;
            rsp_status_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    row_total_reg[ini_row_reg] <= row_total_reg[ini_row_reg] + TW'(init_w);
                    grand_reg    <= grand_reg + TW'(init_w);
                    ini_addr_reg <= ini_addr_reg + 1'b1;
                    if (ini_col_reg == IW'(MAX_VERTS))
                    begin
                        ini_col_reg <= '0;
                        ini_row_reg <= ini_row_reg + 1'b1;
                    end
                    else
                    begin
                        ini_col_reg <= ini_col_reg + 1'b1;
                    end
                    if (ini_addr_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        cmd_reg       <= req.command;
                        r_reg         <= req.eye_count;
                        c_reg         <= req.light_count;
                        r_idx_reg     <= IW'(req.eye_count);
                        idx_reg       <= AW'(int'(req.eye_count) * SIDE +
                                             int'(req.light_count));
                        x_reg         <= req.contribution;
                        rc_reg        <= req.rand_col;
                        status_reg    <= (req.command == asts_pkg::CMD_ACCUM) &&
                                         req.contribution[31];
                        wsel_reg      <= '0;
                        prod_reg      <= DW'(req.rand_row) * DW'(grand_reg);
                        cum_reg       <= '0;
                        row_reg       <= '0;
                        col_reg       <= '0;
                        case (req.command)
                            asts_pkg::CMD_ACCUM:
                            begin
                                state_reg <= in_range ? S_RD : S_DONE;
                            end
                            asts_pkg::CMD_QUERY:
                            begin
                                state_reg <= in_range ? S_RD : S_DONE;
                            end
                            asts_pkg::CMD_SAMPLE:
                            begin
                                state_reg <= S_ROW;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                        prob_reg <= '0;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_USE;
                end
                S_USE:
                begin
                    old_reg  <= rd_w;
                    n_reg    <= rd_n;
                    wsel_reg <= rd_w;
                    mul_reg  <= rd_w * rd_n;
                    if (cmd_reg == asts_pkg::CMD_ACCUM && !status_reg)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_SHARE;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIVQ;
                end
                S_DIVQ:
                begin
                    if (div_st.done)
                    begin
                        row_total_reg[r_idx_reg] <= row_total_reg[r_idx_reg] -
                                                    TW'(old_reg) + TW'(nw);
                        grand_reg <= grand_reg - TW'(old_reg) + TW'(nw);
                        wsel_reg  <= nw;
                        state_reg <= S_SHARE;
                    end
                end
                S_SHARE:
                begin
                    if (grand_reg == '0)
                    begin
                        prob_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIVS;
                    end
                end
                S_DIVS:
                begin
                    if (div_st.done)
                    begin
                        prob_reg  <= div_q[asts_pkg::PROB_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_ROW:
                begin
                    if (row_go)
                    begin
                        cum_reg <= row_cum;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        cum_reg   <= '0;
                        col_reg   <= '0;
                        lim_reg   <= IW'(MAX_VERTS) - row_reg;
                        prod_reg  <= DW'(rc_reg) * DW'(rt_cur);
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CCHK;
                end
                S_CCHK:
                begin
                    if (col_go)
                    begin
                        cum_reg   <= col_cum;
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                    else
                    begin
                        wsel_reg  <= rd_w;
                        r_reg     <= XW'(row_reg);
                        c_reg     <= XW'(col_reg);
                        state_reg <= S_SHARE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_row_reg    <= r_reg;
                        rsp_col_reg    <= c_reg;
                        rsp_prob_reg   <= prob_reg;
                        rsp_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.row_out     = rsp_row_reg;
    assign rsp.col_out     = rsp_col_reg;
    assign rsp.probability = rsp_prob_reg;
    assign rsp.status      = rsp_status_reg;

    asts_cell_mem #(
        .DEPTH  (CELLS),
        .DATA_W (WW + NW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    asts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_st)
    );

    `ASTS_ASSERT_IMP(a_we_owner, mem_we, (state_reg == S_INIT) || (state_reg == S_DIVQ), "cell write outside sweep or update")
    `ASTS_ASSERT_IMP(a_div_owner, div_st.done, (state_reg == S_DIVQ) || (state_reg == S_DIVS), "divider finished with no waiter")
    `ASTS_ASSERT_NXT(a_one_req, req_fire, !req.ready, "second request taken while one is in flight")
    `ASTS_ASSERT_NXT(a_rsp_load, (state_reg == S_DONE) && out_free, rsp.valid, "finished request produced no response")

endmodule

`default_nettype wire
